@@ src/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the bitmap page allocator
// Operation and status codes, word geometry of the used-page map.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int unsigned DEF_MAX_PAGES  = 4096;
    localparam int unsigned DEF_PAGE_BYTES = 4096;
    localparam int unsigned DEF_ADDR_WIDTH = 32;
    localparam int unsigned WORD_BITS      = 32;

    typedef enum logic [1:0] {
        FN_INIT  = 2'd0,
        FN_ALLOC = 2'd1,
        FN_FREE  = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_REQ  = 3'd1,
        ST_TOO_BIG   = 3'd2,
        ST_NO_RUN    = 3'd3,
        ST_NULL      = 3'd4,
        ST_OOB       = 3'd5,
        ST_TRUNC     = 3'd6,
        ST_RSVD      = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_RSVD2 = 2'd2,
        CFG_RSVD3 = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_OUT
    } t_state;

endpackage

@@ src/bitmap_page_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top: first-fit contiguous page allocator
// Used-page bitmap in a memory of WORD_BITS-bit words, walked bit by bit.
// ----------------------------------------------------------------------------
// Usage:
//  - Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) sets
//    pool_start (0) and pool_size (1); they take effect at the next init.
//  - Slave stream carries one command beat: func, page_count, address.
//  - Master stream returns one result beat: status, block_address,
//    pages_done. The result waits in an output register while stalled; the
//    block takes no new command until it has been taken.
//  - Init: the map is cleared one map word per cycle, then the map pages
//    are marked (1 page for the default pool).
//  - Alloc: the map is walked one page bit at a time through the single
//    word read port (read, then examine) up to pool_pages, then the found
//    run is marked.
//  - Free: pages are cleared one at a time (read-modify-write).
//  - Reset clears the map by a sweep over all map words, during which no
//    command beat is accepted; config writes are always taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int unsigned MAX_PAGES  = DEF_MAX_PAGES,
    parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] func, [17:2] page_count, [49:18] address, [55:50] zero
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [34:3] block_address, [50:35] pages_done, [55:51] zero
    output logic [55:0] m_axis_tdata
);
    localparam int unsigned PW    = $clog2(MAX_PAGES + 1);  // page count width
    localparam int unsigned IW    = $clog2(MAX_PAGES);      // page index width
    localparam int unsigned NWORD = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WW    = (NWORD > 1) ? $clog2(NWORD) : 1;
    localparam int unsigned BW    = $clog2(WORD_BITS);
    localparam int unsigned OW    = $clog2(PAGE_BYTES);
    localparam int unsigned XW    = ADDR_WIDTH + 1;         // unmasked sum width
    localparam int unsigned MAPPW = ((MAX_PAGES + 7) / 8 + PAGE_BYTES - 1) / PAGE_BYTES + 1;
    localparam int unsigned MW    = $clog2(MAPPW + 1);
    localparam logic [ADDR_WIDTH-1:0] AMASK = ADDR_WIDTH'(PAGE_BYTES - 1);

    // Configuration
    logic [31:0] r_start, r_size;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_size  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START: r_start <= i_cfg_data;
                CFG_SIZE:  r_size  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Map memory
    logic [WORD_BITS-1:0] r_mem [NWORD];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [WW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    // Control and pool state
    t_state r_state, n_state;
    logic [ADDR_WIDTH-1:0] r_base;
    logic [PW-1:0]  r_pages;
    logic [IW:0]    r_idx;       // current page, one extra bit for end
    logic [IW:0]    r_end;       // bound of the current walk
    logic [IW:0]    r_first;
    logic [16:0]    r_run;
    logic [15:0]    r_count;
    logic           r_phase;     // 0 read issued, 1 data valid
    logic           r_mark;      // clear sweep followed by map marking
    logic [2:0]     r_st;
    logic [31:0]    r_addr_o;
    logic [15:0]    r_done;
    logic [WW:0]    r_wcnt;

    logic [1:0]  in_func;
    logic [15:0] in_cnt;
    logic [31:0] in_addr;
    assign in_func = s_axis_tdata[1:0];
    assign in_cnt  = s_axis_tdata[17:2];
    assign in_addr = s_axis_tdata[49:18];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_done, r_addr_o, r_st};

    logic [IW-1:0] cur;
    logic [BW-1:0] bsel;
    logic          cur_bit;
    assign cur     = r_idx[IW-1:0];
    assign bsel    = BW'(cur % WORD_BITS);
    assign cur_bit = r_rdata[bsel];

    // Init arithmetic, one add/compare chain on the configured values
    logic [ADDR_WIDTH-1:0] st_a, rem, shift, base_n;
    logic [32:0]           size_n;
    logic [32:0]           npg_raw;
    logic [PW-1:0]         npg;
    logic [PW+3:0]         mbytes;
    logic [MW-1:0]         mpages;
    always_comb begin
        st_a    = ADDR_WIDTH'(r_start);
        rem     = st_a & AMASK;
        shift   = (rem != '0) ? ADDR_WIDTH'(PAGE_BYTES) - rem : '0;
        size_n  = ({1'b0, r_size} > 33'(shift)) ? {1'b0, r_size} - 33'(shift) : '0;
        base_n  = st_a + shift;
        npg_raw = size_n >> OW;
        npg     = (npg_raw > 33'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(npg_raw);
        mbytes  = ((PW+4)'(npg) + (PW+4)'(7)) >> 3;
        mpages  = MW'((mbytes + (PW+4)'(PAGE_BYTES - 1)) >> OW);
    end

    // Free bounds: unmasked range compare
    logic [XW+PW:0] pend;
    logic           out_lo, out_hi;
    logic [ADDR_WIDTH-1:0] rel;
    logic [IW:0]    ffirst;
    logic [IW+16:0] fsum;
    always_comb begin
        pend   = (XW+PW+1)'(r_base) + ((XW+PW+1)'(r_pages) << OW);
        out_lo = ADDR_WIDTH'(in_addr) < r_base;
        out_hi = (XW+PW+1)'(in_addr) >= pend;
        rel    = ADDR_WIDTH'(in_addr) - r_base;
        ffirst = (IW+1)'(rel >> OW);
        fsum   = (IW+17)'(ffirst) + (IW+17)'(in_cnt);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) begin
                unique case (t_func'(in_func))
                    FN_INIT:  n_state = S_CLEAR;
                    FN_ALLOC: n_state = (in_cnt == 0 || 17'(in_cnt) > 17'(r_pages)) ? S_OUT
                                       : S_SCAN;
                    FN_FREE:  n_state = (in_addr == 0 || out_lo || out_hi) ? S_OUT : S_FREE;
                    default:  n_state = S_OUT;
                endcase
            end
            S_CLEAR: if (r_wcnt == (WW+1)'(NWORD - 1))
                         n_state = r_mark ? S_MARK : S_IDLE;
            S_SCAN:  if (r_idx >= r_end) n_state = S_OUT;
                     else if (r_phase && !cur_bit && r_run + 17'd1 == 17'(r_count))
                         n_state = S_MARK;
            S_MARK:  if (r_idx >= r_end) n_state = S_OUT;
            S_FREE:  if (r_idx >= r_end) n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = WW'(cur / WORD_BITS);
        mem_raddr = WW'(cur / WORD_BITS);
        mem_wdata = r_rdata;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_wcnt[WW-1:0];
                mem_wdata = '0;
            end
            S_MARK, S_FREE: if (r_phase && r_idx < r_end) begin
                mem_we          = 1'b1;
                mem_wdata[bsel] = (r_state == S_MARK);
            end
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mark  <= 1'b0;
            r_wcnt  <= '0;
            r_base  <= '0;
            r_pages <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_phase  <= 1'b0;
                    r_run    <= '0;
                    r_count  <= in_cnt;
                    unique case (t_func'(in_func))
                        FN_INIT: begin
                            r_st     <= ST_OK;
                            r_idx    <= '0;
                            r_wcnt   <= '0;
                            r_mark   <= 1'b1;
                            r_base   <= base_n;
                            r_pages  <= npg;
                            r_end    <= ((IW+1)'(mpages) > (IW+1)'(MAX_PAGES))
                                        ? (IW+1)'(MAX_PAGES) : (IW+1)'(mpages);
                            r_addr_o <= 32'(base_n + (ADDR_WIDTH'(mpages) << OW));
                            r_done   <= 16'(npg);
                        end
                        FN_ALLOC: begin
                            r_idx    <= '0;
                            r_addr_o <= '0;
                            r_done   <= '0;
                            r_end    <= (IW+1)'(r_pages);
                            if (in_cnt == 0) r_st <= ST_ZERO_REQ;
                            else if (17'(in_cnt) > 17'(r_pages)) r_st <= ST_TOO_BIG;
                            else r_st <= ST_OK;
                        end
                        FN_FREE: begin
                            r_idx    <= ffirst;
                            r_addr_o <= '0;
                            if (in_addr == 0) begin
                                r_st   <= ST_NULL;
                                r_done <= '0;
                            end else if (out_lo || out_hi) begin
                                r_st   <= ST_OOB;
                                r_done <= '0;
                            end else if (fsum > (IW+17)'(r_pages)) begin
                                r_st   <= ST_TRUNC;
                                r_end  <= (IW+1)'(r_pages);
                                r_done <= 16'(r_pages - PW'(ffirst));
                            end else begin
                                r_st   <= ST_OK;
                                r_end  <= (IW+1)'(fsum);
                                r_done <= in_cnt;
                            end
                        end
                        default: begin
                            r_st     <= ST_OK;
                            r_idx    <= '0;
                            r_addr_o <= '0;
                            r_done   <= '0;
                        end
                    endcase
                end
                S_CLEAR: r_wcnt <= r_wcnt + 1'b1;
                S_SCAN: begin
                    r_phase <= ~r_phase;
                    if (r_idx >= r_end) begin
                        r_st <= ST_NO_RUN;
                    end else if (r_phase) begin
                        if (cur_bit) r_run <= '0;
                        else begin
                            if (r_run == 0) r_first <= r_idx;
                            r_run <= r_run + 1'b1;
                            if (r_run + 17'd1 == 17'(r_count)) begin
                                r_addr_o <= 32'(r_base + (ADDR_WIDTH'(
                                    (r_run == 0) ? r_idx : r_first) << OW));
                                r_done   <= r_count;
                                r_end    <= r_idx + 1'b1;
                                r_idx    <= (r_run == 0) ? r_idx : r_first;
                            end else r_idx <= r_idx + 1'b1;
                        end
                        if (cur_bit) r_idx <= r_idx + 1'b1;
                    end
                end
                S_MARK, S_FREE: begin
                    r_mark  <= 1'b0;
                    r_phase <= ~r_phase;
                    if (r_phase) r_idx <= r_idx + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Assertions
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("command taken with result pending");
    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_end <= (IW+1)'(MAX_PAGES))
        else $error("scan bound past map");
endmodule
